>>> sv/scrs_pkg.sv
// Shared constants, codes and types for the sound chip register shadow.
`timescale 1ns / 1ps

package scrs_pkg;

   // Shadow file sizes
   localparam int FM_A_REGS = 57;
   localparam int FM_B_REGS = 439;
   localparam int PSG_REGS  = 8;

   localparam int FM_A_AW   = (FM_A_REGS > 1) ? $clog2(FM_A_REGS) : 1;
   localparam int FM_B_AW   = (FM_B_REGS > 1) ? $clog2(FM_B_REGS) : 1;
   localparam int CLR_DEPTH = (FM_A_REGS > FM_B_REGS) ? FM_A_REGS : FM_B_REGS;
   localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

   // Item commands
   localparam logic CMD_APPLY = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Log opcodes
   localparam logic [7:0] OP_STEREO  = 8'h4F;
   localparam logic [7:0] OP_PSG     = 8'h50;
   localparam logic [7:0] OP_FM_A    = 8'h51;
   localparam logic [7:0] OP_FM_B_LO = 8'h52;
   localparam logic [7:0] OP_FM_B_HI = 8'h53;
   localparam logic [7:0] OP_WAIT    = 8'h61;
   localparam logic [7:0] OP_WAIT_60 = 8'h62;
   localparam logic [7:0] OP_WAIT_50 = 8'h63;
   localparam logic [3:0] OP_SHORT_WAIT_HI = 4'h7;

   // Read spaces
   localparam logic [1:0] SPACE_PSG  = 2'd0;
   localparam logic [1:0] SPACE_CTL  = 2'd1;
   localparam logic [1:0] SPACE_FM_A = 2'd2;
   localparam logic [1:0] SPACE_FM_B = 2'd3;

   // Control register indexes
   localparam logic CSR_WAIT_60 = 1'b0;
   localparam logic CSR_WAIT_50 = 1'b1;

   // Reset values
   localparam logic [15:0] WAIT_60_RESET = 16'd735;
   localparam logic [15:0] WAIT_50_RESET = 16'd882;
   localparam logic [7:0]  STEREO_RESET  = 8'hFF;
   localparam logic [9:0]  PSG_ODD_RESET = 10'h00F;

   typedef enum logic [1:0] {
      SEL_DIRECT,
      SEL_FM_A,
      SEL_FM_B
   } rd_sel_type;

   typedef struct packed {
      logic       stereo_wr;
      logic       psg_wr;
      logic [7:0] wdata;
   } psg_ctl_type;

endpackage

>>> sv/scrs_ifs.sv
// Handshake channel interfaces: request, response and control register write.
`timescale 1ns / 1ps

interface scrs_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] opcode;
   logic [7:0] data_low;
   logic [7:0] data_high;
   logic [1:0] read_space;
   logic [8:0] read_index;

   modport source (output valid, cmd, opcode, data_low, data_high, read_space, read_index,
                   input ready);
   modport sink   (input valid, cmd, opcode, data_low, data_high, read_space, read_index,
                   output ready);
endinterface

interface scrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  read_data;
   logic [31:0] sample_count;

   modport source (output valid, read_data, sample_count, input ready);
   modport sink   (input valid, read_data, sample_count, output ready);
endinterface

interface scrs_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/sound_chip_register_shadow_unit.sv
// Top level of the sound chip register shadow: FM files, sample counter, pipeline.
`timescale 1ns / 1ps
//
// Tracks the register state of three sound chips from a stream of decoded
// music-log commands.
// req_ch  : one item per handshake. cmd 0 applies a log command (stereo,
//           PSG latch/data, FM-A and FM-B register writes, waits); cmd 1
//           reads one shadow value selected by read_space and read_index.
// rsp_ch  : exactly one item per request, in order: read_data (zero for
//           commands and out-of-range reads) and the running 32-bit sample
//           count after that request.
// csr_ch  : writes the two wait lengths (index 0: 1/60 s, 1: 1/50 s); always
//           ready. Write only while the block is idle.
// A request passes the RAM read stage and then the output register before its
// response is valid; the FM files sit in synchronous RAMs with registered read
// data. Throughput is one item per cycle unless the receiver stalls.
// After reset the FM files are cleared by a sweep over the larger file depth
// (439 entries), one entry per cycle; req_ch.ready stays low during it.
// When the receiver stalls, one result waits in the output register and one
// more item is still taken into the RAM read stage; then ready drops.
//

module sound_chip_register_shadow_unit
   import scrs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   scrs_req_if.sink   req_ch,
   scrs_rsp_if.source rsp_ch,
   scrs_csr_if.sink   csr_ch
);

   logic [7:0] fm_a_mem [FM_A_REGS];
   logic [7:0] fm_b_mem [FM_B_REGS];
   logic [7:0] fm_a_rdata_ff, fm_b_rdata_ff;

   logic             clr_active_ff, clr_active_in;
   logic [CLR_W-1:0] clr_ff, clr_in;

   logic [15:0] wait60_ff, wait60_in;
   logic [15:0] wait50_ff, wait50_in;
   logic [31:0] samples_ff, samples_in;
   logic [31:0] delta;

   logic        s1_valid_ff, s1_valid_in;
   rd_sel_type  s1_sel_ff, s1_sel_in;
   logic [9:0]  s1_direct_ff, s1_direct_in;
   logic [31:0] s1_count_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [9:0]  rsp_data_ff, rsp_data_in;
   logic [31:0] rsp_count_ff;

   logic accept, out_take, s1_move, is_apply;
   logic fm_a_we, fm_b_we;
   logic [FM_A_AW-1:0] fm_a_waddr;
   logic [FM_B_AW-1:0] fm_b_waddr;
   logic [7:0] fm_a_wdata, fm_b_wdata;
   logic [8:0] fm_b_idx;
   logic       fm_a_hit, fm_b_hit, rd_a_hit, rd_b_hit;
   logic [9:0] psg_value;
   psg_ctl_type psg_ctl;

   // ---------------- handshake ----------------
   assign out_take     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_move      = s1_valid_ff && out_take;
   assign req_ch.ready = !clr_active_ff && (!s1_valid_ff || out_take);
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_apply     = (req_ch.cmd == CMD_APPLY);
   assign csr_ch.ready = 1'b1;

   // ---------------- clearing sweep ----------------
   always_comb begin
      clr_in        = clr_ff;
      clr_active_in = clr_active_ff;
      if (clr_active_ff) begin
         if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end else begin
            clr_in = clr_ff + 1'b1;
         end
      end
   end

   // ---------------- FM writes ----------------
   assign fm_b_idx = {req_ch.opcode == OP_FM_B_HI, req_ch.data_low};
   assign fm_a_hit = 9'(req_ch.data_low) < 9'(FM_A_REGS);
   assign fm_b_hit = 10'(fm_b_idx) < 10'(FM_B_REGS);
   assign rd_a_hit = 10'(req_ch.read_index) < 10'(FM_A_REGS);
   assign rd_b_hit = 10'(req_ch.read_index) < 10'(FM_B_REGS);

   always_comb begin
      if (clr_active_ff) begin
         fm_a_we    = (CLR_W + 1)'(clr_ff) < (CLR_W + 1)'(FM_A_REGS);
         fm_b_we    = (CLR_W + 1)'(clr_ff) < (CLR_W + 1)'(FM_B_REGS);
         fm_a_waddr = clr_ff[FM_A_AW-1:0];
         fm_b_waddr = clr_ff[FM_B_AW-1:0];
         fm_a_wdata = 8'd0;
         fm_b_wdata = 8'd0;
      end else begin
         fm_a_we    = accept && is_apply && req_ch.opcode == OP_FM_A && fm_a_hit;
         fm_b_we    = accept && is_apply && fm_b_hit &&
                      (req_ch.opcode == OP_FM_B_LO || req_ch.opcode == OP_FM_B_HI);
         fm_a_waddr = req_ch.data_low[FM_A_AW-1:0];
         fm_b_waddr = fm_b_idx[FM_B_AW-1:0];
         fm_a_wdata = req_ch.data_high;
         fm_b_wdata = req_ch.data_high;
      end
   end

   // Read data only advances on accept, so it holds while the read stage stalls.
   always_ff @(posedge clock) begin
      if (fm_a_we) begin
         fm_a_mem[fm_a_waddr] <= fm_a_wdata;
      end
      if (accept) begin
         fm_a_rdata_ff <= fm_a_mem[req_ch.read_index[FM_A_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (fm_b_we) begin
         fm_b_mem[fm_b_waddr] <= fm_b_wdata;
      end
      if (accept) begin
         fm_b_rdata_ff <= fm_b_mem[req_ch.read_index[FM_B_AW-1:0]];
      end
   end

   // ---------------- PSG shadow ----------------
   assign psg_ctl.stereo_wr = accept && is_apply && req_ch.opcode == OP_STEREO;
   assign psg_ctl.psg_wr    = accept && is_apply && req_ch.opcode == OP_PSG;
   assign psg_ctl.wdata     = req_ch.data_low;

   scrs_psg u_psg (
      .clock      (clock),
      .reset      (reset),
      .ctl        (psg_ctl),
      .read_space (req_ch.read_space),
      .read_index (req_ch.read_index),
      .rd_value   (psg_value)
   );

   // ---------------- wait counter ----------------
   always_comb begin
      delta = 32'd0;
      if (is_apply) begin
         case (req_ch.opcode)
            OP_WAIT:    delta = {16'd0, req_ch.data_high, req_ch.data_low};
            OP_WAIT_60: delta = {16'd0, wait60_ff};
            OP_WAIT_50: delta = {16'd0, wait50_ff};
            default: begin
               if (req_ch.opcode[7:4] == OP_SHORT_WAIT_HI) begin
                  delta = 32'(req_ch.opcode[3:0]) + 32'd1;
               end
            end
         endcase
      end
   end

   assign samples_in = accept ? samples_ff + delta : samples_ff;

   always_comb begin
      wait60_in = wait60_ff;
      wait50_in = wait50_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_WAIT_60: wait60_in = csr_ch.data;
            CSR_WAIT_50: wait50_in = csr_ch.data;
            default:     wait60_in = wait60_ff;
         endcase
      end
   end

   // ---------------- read stage ----------------
   always_comb begin
      s1_sel_in    = SEL_DIRECT;
      s1_direct_in = 10'd0;
      if (!is_apply) begin
         case (req_ch.read_space)
            SPACE_FM_A: s1_sel_in = rd_a_hit ? SEL_FM_A : SEL_DIRECT;
            SPACE_FM_B: s1_sel_in = rd_b_hit ? SEL_FM_B : SEL_DIRECT;
            default:    s1_direct_in = psg_value;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (s1_sel_ff)
         SEL_FM_A: rsp_data_in = {2'd0, fm_a_rdata_ff};
         SEL_FM_B: rsp_data_in = {2'd0, fm_b_rdata_ff};
         default:  rsp_data_in = s1_direct_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_ff        <= '0;
         wait60_ff     <= WAIT_60_RESET;
         wait50_ff     <= WAIT_50_RESET;
         samples_ff    <= 32'd0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_ff        <= clr_in;
         wait60_ff     <= wait60_in;
         wait50_ff     <= wait50_in;
         samples_ff    <= samples_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sel_ff    <= s1_sel_in;
         s1_direct_ff <= s1_direct_in;
         s1_count_ff  <= samples_in;
      end
      if (s1_move) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_count_ff <= s1_count_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.read_data    = rsp_data_ff;
   assign rsp_ch.sample_count = rsp_count_ff;

endmodule

>>> sv/scrs_psg.sv
// PSG shadow: tone/volume registers, latched register number and stereo mask.
`timescale 1ns / 1ps

module scrs_psg
   import scrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  psg_ctl_type ctl,
   input  logic [1:0]  read_space,
   input  logic [8:0]  read_index,
   output logic [9:0]  rd_value
);

   logic [9:0] psg_reg_ff [PSG_REGS];
   logic [9:0] psg_reg_in [PSG_REGS];
   logic [2:0] latch_ff, latch_in;
   logic [7:0] stereo_ff, stereo_in;
   logic [2:0] tgt;

   // Each entry decides on its own whether it is hit, so only the read side muxes.
   always_comb begin
      tgt        = ctl.wdata[7] ? ctl.wdata[6:4] : latch_ff;
      latch_in   = latch_ff;
      stereo_in  = stereo_ff;
      psg_reg_in = psg_reg_ff;
      if (ctl.stereo_wr) begin
         stereo_in = ctl.wdata;
      end
      if (ctl.psg_wr && ctl.wdata[7]) begin
         latch_in = ctl.wdata[6:4];
      end
      for (int i = 0; i < PSG_REGS; i++) begin
         if (ctl.psg_wr && tgt == 3'(i)) begin
            if (ctl.wdata[7]) begin
               psg_reg_in[i] = {psg_reg_ff[i][9:4], ctl.wdata[3:0]};
            end else if (i == 0 || i == 2 || i == 4) begin
               // tone registers take the upper six bits
               psg_reg_in[i] = {ctl.wdata[5:0], psg_reg_ff[i][3:0]};
            end else begin
               psg_reg_in[i] = {6'd0, ctl.wdata[3:0]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PSG_REGS; i++) begin
            psg_reg_ff[i] <= (i % 2 == 1) ? PSG_ODD_RESET : 10'd0;
         end
         latch_ff  <= 3'd0;
         stereo_ff <= STEREO_RESET;
      end else begin
         psg_reg_ff <= psg_reg_in;
         latch_ff   <= latch_in;
         stereo_ff  <= stereo_in;
      end
   end

   always_comb begin
      rd_value = 10'd0;
      case (read_space)
         SPACE_PSG: begin
            if (read_index < 9'(PSG_REGS)) begin
               rd_value = psg_reg_ff[read_index[2:0]];
            end
         end
         SPACE_CTL: begin
            if (read_index == 9'd0) begin
               rd_value = {2'd0, stereo_ff};
            end else if (read_index == 9'd1) begin
               rd_value = {7'd0, latch_ff};
            end
         end
         default: begin
            rd_value = 10'd0;
         end
      endcase
   end

endmodule

>>> sv/scrs_check.sv
// Port-level checks for the sound chip register shadow, bound to the top level.
`timescale 1ns / 1ps

module scrs_check
   import scrs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   scrs_req_if.sink   req_ch,
   scrs_rsp_if.source rsp_ch,
   scrs_csr_if.sink   csr_ch
);

   logic req_acc;
   assign req_acc = req_ch.valid && req_ch.ready;

   // the clearing sweep holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ch.ready)
      else $error("request taken during clearing sweep");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=>
         (rsp_ch.valid && $stable(rsp_ch.read_data) && $stable(rsp_ch.sample_count)))
      else $error("stalled response changed");

   // every item reaches the output after the read stage, or is queued behind a stall
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> ##2 rsp_ch.valid)
      else $error("response missing after accepted item");

   a_cmd_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_ch.cmd == CMD_APPLY) ##1 !rsp_ch.valid |=> rsp_ch.read_data == 10'd0)
      else $error("command item returned nonzero data");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ch.ready)
      else $error("control write channel not ready");

endmodule

bind sound_chip_register_shadow_unit scrs_check u_scrs_check (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch),
   .csr_ch (csr_ch)
);

>>> tb/tb.sv
// Testbench for the sound chip register shadow: random and directed log commands, scoreboard.
`timescale 1ns / 1ps

module tb;
   import scrs_pkg::*;

   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [9:0]  read_data;
      logic [31:0] sample_count;
   } shadow_readback_type;

   // Shadow copy of the three chips plus the queue of readbacks still owed.
   class shadow_book;
      logic [9:0]  psg_regs [PSG_REGS];
      logic [2:0]  psg_latch;
      logic [7:0]  stereo;
      logic [7:0]  fm_a [FM_A_REGS];
      logic [7:0]  fm_b [FM_B_REGS];
      logic [31:0] samples;
      logic [15:0] wait_60;
      logic [15:0] wait_50;
      shadow_readback_type pending [$];
      int mismatches;

      function new();
         for (int i = 0; i < PSG_REGS; i++)
            psg_regs[i] = i[0] ? PSG_ODD_RESET : 10'd0;
         psg_latch = 3'd0;
         stereo = STEREO_RESET;
         foreach (fm_a[i]) fm_a[i] = 8'd0;
         foreach (fm_b[i]) fm_b[i] = 8'd0;
         samples = 32'd0;
         wait_60 = WAIT_60_RESET;
         wait_50 = WAIT_50_RESET;
         mismatches = 0;
      endfunction

      function void set_wait(logic index, logic [15:0] value);
         if (index == CSR_WAIT_60)
            wait_60 = value;
         else
            wait_50 = value;
      endfunction

      function void play_psg_byte(logic [7:0] b);
         logic [2:0] r;
         if (b[7]) begin
            r = b[6:4];
            psg_latch = r;
            psg_regs[r] = {psg_regs[r][9:4], b[3:0]};
         end else begin
            r = psg_latch;
            // tone registers 0, 2 and 4 take the high six bits
            if (!r[0] && r < 3'd5)
               psg_regs[r] = {b[5:0], psg_regs[r][3:0]};
            else
               psg_regs[r] = {6'd0, b[3:0]};
         end
      endfunction

      function void play_command(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
         logic [8:0] fm_b_index;
         case (op)
            OP_STEREO: stereo = lo;
            OP_PSG: play_psg_byte(lo);
            OP_FM_A: if (lo < FM_A_REGS) fm_a[lo] = hi;
            OP_FM_B_LO, OP_FM_B_HI: begin
               fm_b_index = {op == OP_FM_B_HI, lo};
               if (fm_b_index < FM_B_REGS) fm_b[fm_b_index] = hi;
            end
            OP_WAIT: samples = samples + {16'd0, hi, lo};
            OP_WAIT_60: samples = samples + {16'd0, wait_60};
            OP_WAIT_50: samples = samples + {16'd0, wait_50};
            default: begin
               if (op[7:4] == OP_SHORT_WAIT_HI)
                  samples = samples + {28'd0, op[3:0]} + 32'd1;
            end
         endcase
      endfunction

      function logic [9:0] look_up(logic [1:0] space, logic [8:0] idx);
         case (space)
            SPACE_PSG: begin
               if (idx < PSG_REGS) return psg_regs[idx[2:0]];
            end
            SPACE_CTL: begin
               if (idx == 9'd0) return {2'd0, stereo};
               if (idx == 9'd1) return {7'd0, psg_latch};
            end
            SPACE_FM_A: begin
               if (idx < FM_A_REGS) return {2'd0, fm_a[idx]};
            end
            default: begin
               if (idx < FM_B_REGS) return {2'd0, fm_b[idx]};
            end
         endcase
         return 10'd0;
      endfunction

      function void note_item(logic cmd, logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                              logic [1:0] space, logic [8:0] idx);
         shadow_readback_type r;
         r.read_data = 10'd0;
         if (cmd == CMD_APPLY)
            play_command(op, lo, hi);
         else
            r.read_data = look_up(space, idx);
         r.sample_count = samples;
         pending.push_back(r);
      endfunction

      function void check_result(logic [9:0] read_data, logic [31:0] sample_count);
         shadow_readback_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected item: read_data %0d sample_count %0d",
                     $time, read_data, sample_count);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (read_data !== want.read_data) begin
            $display("%0t: read_data expected %0d got %0d", $time, want.read_data, read_data);
            mismatches++;
         end
         if (sample_count !== want.sample_count) begin
            $display("%0t: sample_count expected %0d got %0d",
                     $time, want.sample_count, sample_count);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   tx_gap_pct;
   int   rx_stall_pct;
   bit   hold_request;
   shadow_book book = new();

   scrs_req_if req_ch();
   scrs_rsp_if rsp_ch();
   scrs_csr_if csr_ch();

   sound_chip_register_shadow_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            book.set_wait(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready)
            book.note_item(req_ch.cmd, req_ch.opcode, req_ch.data_low, req_ch.data_high,
                           req_ch.read_space, req_ch.read_index);
         if (rsp_ch.valid && rsp_ch.ready)
            book.check_result(rsp_ch.read_data, rsp_ch.sample_count);
      end
   end

   // Receiver: random stalls, or one long hold-off on request.
   initial begin
      int held;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   task automatic send_item(logic cmd, logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                            logic [1:0] space, logic [8:0] idx);
      while ($urandom_range(99) < tx_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.cmd        <= cmd;
      req_ch.opcode     <= op;
      req_ch.data_low   <= lo;
      req_ch.data_high  <= hi;
      req_ch.read_space <= space;
      req_ch.read_index <= idx;
      req_ch.valid      <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic issue_command(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
      send_item(CMD_APPLY, op, lo, hi, 2'($urandom_range(3)), 9'($urandom_range(511)));
   endtask

   task automatic issue_read(logic [1:0] space, logic [8:0] idx);
      send_item(CMD_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), space, idx);
   endtask

   task automatic send_random_item();
      logic       cmd;
      logic [7:0] op;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [1:0] space;
      logic [8:0] idx;
      op    = 8'($urandom_range(255));
      lo    = 8'($urandom_range(255));
      hi    = 8'($urandom_range(255));
      space = 2'($urandom_range(3));
      idx   = 9'($urandom_range(511));
      if ($urandom_range(99) < 35) begin
         cmd = CMD_READ;
         if ($urandom_range(99) < 80) begin
            case (space)
               SPACE_PSG: idx = 9'($urandom_range(PSG_REGS - 1));
               SPACE_CTL: idx = 9'($urandom_range(1));
               SPACE_FM_A: idx = 9'($urandom_range(FM_A_REGS - 1));
               // FM-B writes cluster low in each port, so often look low in the high port
               default: idx = $urandom_range(1) ? 9'(9'h100 + $urandom_range(15))
                                                : 9'($urandom_range(FM_B_REGS - 1));
            endcase
         end
      end else begin
         cmd = CMD_APPLY;
         case ($urandom_range(9))
            0: op = OP_STEREO;
            1, 2: op = OP_PSG;
            3: begin
               op = OP_FM_A;
               if ($urandom_range(99) < 85) lo = 8'($urandom_range(FM_A_REGS - 1));
            end
            4: begin
               op = OP_FM_B_LO;
               if ($urandom_range(1)) lo = 8'($urandom_range(15));
            end
            5: begin
               op = OP_FM_B_HI;
               if ($urandom_range(99) < 80) lo = 8'($urandom_range(15));
            end
            6: op = OP_WAIT;
            7: op = $urandom_range(1) ? OP_WAIT_60 : OP_WAIT_50;
            8: op = {OP_SHORT_WAIT_HI, 4'($urandom_range(15))};
            default: ;
         endcase
      end
      send_item(cmd, op, lo, hi, space, idx);
   endtask

   task automatic set_wait_lengths(logic [15:0] w60, logic [15:0] w50);
      csr_ch.index <= CSR_WAIT_60;
      csr_ch.data  <= w60;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.index <= CSR_WAIT_50;
      csr_ch.data  <= w50;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (book.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_phase(int n, int tx_pct, int rx_pct);
      tx_gap_pct   = tx_pct;
      rx_stall_pct = rx_pct;
      repeat (n) send_random_item();
      drain();
   endtask

   initial begin
      tx_gap_pct   = 0;
      rx_stall_pct = 0;
      hold_request = 1'b0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.cmd        <= CMD_APPLY;
      req_ch.opcode     <= 8'd0;
      req_ch.data_low   <= 8'd0;
      req_ch.data_high  <= 8'd0;
      req_ch.read_space <= SPACE_PSG;
      req_ch.read_index <= 9'd0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= CSR_WAIT_60;
      csr_ch.data       <= 16'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, PSG latch/data paths, file edges, all waits
      issue_read(SPACE_PSG, 9'd1);
      issue_read(SPACE_CTL, 9'd0);
      issue_command(OP_STEREO, 8'h00, 8'h00);
      issue_command(OP_PSG, 8'hFF, 8'h00);
      issue_command(OP_PSG, 8'h3A, 8'h00);
      issue_command(OP_PSG, 8'h8C, 8'h00);
      issue_command(OP_PSG, 8'h7F, 8'h00);
      issue_command(OP_PSG, 8'hE5, 8'h00);
      issue_command(OP_PSG, 8'h2C, 8'h00);
      issue_read(SPACE_PSG, 9'd0);
      issue_read(SPACE_PSG, 9'd6);
      issue_read(SPACE_CTL, 9'd1);
      issue_command(OP_FM_A, 8'd56, 8'hFF);
      issue_command(OP_FM_A, 8'd57, 8'hAA);
      issue_command(OP_FM_B_HI, 8'hB6, 8'h55);
      issue_command(OP_FM_B_HI, 8'hB7, 8'h77);
      issue_command(OP_FM_B_LO, 8'hFF, 8'hAA);
      issue_read(SPACE_FM_A, 9'd56);
      issue_read(SPACE_FM_B, 9'd438);
      issue_read(SPACE_FM_B, 9'd439);
      issue_read(SPACE_PSG, 9'd511);
      issue_read(SPACE_CTL, 9'd2);
      issue_command(OP_WAIT, 8'hFF, 8'hFF);
      issue_command(OP_WAIT_60, 8'h00, 8'h00);
      issue_command(OP_WAIT_50, 8'h00, 8'h00);
      issue_command({OP_SHORT_WAIT_HI, 4'h0}, 8'h00, 8'h00);
      issue_command({OP_SHORT_WAIT_HI, 4'hF}, 8'h00, 8'h00);
      issue_command(8'h00, 8'h12, 8'h34);
      issue_command(8'hFF, 8'h56, 8'h78);

      // a run of maximal waits back to back
      repeat (20) issue_command(OP_WAIT, 8'hFF, 8'hFF);
      drain();

      set_wait_lengths(16'd0, 16'hFFFF);
      hold_request = 1'b1;
      random_phase(100, 0, 0);
      set_wait_lengths(16'hFFFF, 16'd0);
      random_phase(100, 59, 0);
      set_wait_lengths(16'($urandom_range(65535)), 16'($urandom_range(65535)));
      random_phase(100, 0, 59);
      set_wait_lengths(16'($urandom_range(65535)), 16'($urandom_range(65535)));
      random_phase(100, 29, 29);
      set_wait_lengths(16'($urandom_range(65535)), 16'($urandom_range(65535)));
      random_phase(100, 0, 0);

      if (book.mismatches == 0 && book.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
sv/scrs_pkg.sv
sv/scrs_ifs.sv
sv/scrs_psg.sv
sv/sound_chip_register_shadow_unit.sv
sv/scrs_check.sv
tb/tb.sv
